// ===== hdl/keyed_record_table_with_sort_defines.svh =====
// assertion macros for the keyed record table
// used by the sequencer; no other dependencies
`ifndef KEYED_RECORD_TABLE_WITH_SORT_DEFINES_SVH
`define KEYED_RECORD_TABLE_WITH_SORT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("krt assertion failed");

// next-cycle implication, disabled during reset
`define KRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("krt assertion failed");

`endif

// ===== hdl/krt_pkg.sv =====
// shared types, widths and codes for the keyed record table
// no dependencies
package krt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH) + 1;

   // field widths
   localparam int ACT_W  = 3;
   localparam int KEY_W  = 31;
   localparam int DAYS_W = 8;
   localparam int RATE_W = 24;
   localparam int PAY_W  = 32;
   localparam int STAT_W = 2;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(300000);

   // action codes
   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_FIND   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SORT   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_LIST   = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [KEY_W-1:0]  record_key;
      logic [DAYS_W-1:0] day_count;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  out_key;
      logic [DAYS_W-1:0] out_days;
      logic [PAY_W-1:0]  out_pay;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DAYS_W-1:0] days;
   } rec_type;

   // record memory write request
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      rec_type          rec;
   } wr_type;

   // result produced by the sequencer, before pay is derived
   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      rec_type           rec;
      logic              last;
   } emit_type;

endpackage

// ===== hdl/krt_mem.sv =====
// record memory: one write port, one registered read port
// depends on krt_pkg
module krt_mem import krt_pkg::*; (
   input  logic             clock,
   input  wr_type           wr,
   input  logic [IDX_W-1:0] rd_addr,
   output rec_type          rd_data
);

   rec_type rec_mem [TABLE_DEPTH];
   rec_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         rec_mem[wr.addr] <= wr.rec;
      end
      rd_data_ff <= rec_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/krt_out.sv =====
// rate register, pay multiplier and result output register
// depends on krt_pkg
module krt_out import krt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [RATE_W-1:0] csr_wr_data,
   input  emit_type          emit,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   logic [RATE_W-1:0] rate_ff;
   logic              valid_ff;
   rsp_type           rsp_ff;
   logic [PAY_W-1:0]  pay;

   // pay rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_wr_en) begin
         rate_ff <= csr_wr_data;
      end
   end

   // days times rate, fits in the pay width
   assign pay = PAY_W'(emit.rec.days) * PAY_W'(rate_ff);

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= emit.valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff.status   <= emit.status;
      rsp_ff.out_key  <= emit.rec.key;
      rsp_ff.out_days <= emit.rec.days;
      rsp_ff.out_pay  <= pay;
      rsp_ff.last     <= emit.last;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/krt_seq.sv =====
// sequencer: key scan, insert, delete shift, update, list and exchange sort
// depends on krt_pkg and the assertion macro header
`include "keyed_record_table_with_sort_defines.svh"

module krt_seq import krt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req,
   input  rec_type          rd_data,
   output logic             busy,
   output logic [IDX_W-1:0] rd_addr,
   output wr_type           wr,
   output emit_type         emit
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DEL, S_DEL_WR, S_LIST, S_LDI, S_LDI_W, S_JRD, S_JCMP
   } state_type;

   state_type         state_ff, state_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DAYS_W-1:0] days_ff, days_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic              pend_ff, pend_in;
   rec_type           cur_ff, cur_in;

   logic             key_eq;
   logic             days_gt;
   logic             idx_lt_cnt;
   logic             pidx_last;
   logic [CNT_W-1:0] idx_p1;
   logic [CNT_W-1:0] i_p1;
   logic [CNT_W-1:0] i_p2;

   // shared compare unit and index arithmetic
   assign key_eq     = pend_ff && (rd_data.key == key_ff);
   assign days_gt    = cur_ff.days > rd_data.days;
   assign idx_lt_cnt = idx_ff < cnt_ff;
   assign idx_p1     = idx_ff + CNT_W'(1);
   assign i_p1       = i_ff + CNT_W'(1);
   assign i_p2       = i_ff + CNT_W'(2);
   assign pidx_last  = (CNT_W'(pidx_ff) + CNT_W'(1)) == cnt_ff;
   assign busy       = state_ff != S_IDLE;

   // next state and datapath control
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      key_in   = key_ff;
      days_in  = days_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      i_in     = i_ff;
      pidx_in  = pidx_ff;
      pend_in  = pend_ff;
      cur_in   = cur_ff;
      rd_addr  = idx_ff[IDX_W-1:0];
      wr       = '0;
      emit     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in  = req.action;
               key_in  = req.record_key;
               days_in = req.day_count;
               idx_in  = '0;
               i_in    = '0;
               pend_in = 1'b0;
               case (req.action)
                  ACT_INSERT, ACT_DELETE, ACT_UPDATE, ACT_FIND: begin
                     state_in = S_SCAN;
                  end
                  ACT_SORT: begin
                     if (cnt_ff < CNT_W'(2)) begin
                        emit.valid  = 1'b1;
                        emit.status = ST_DONE;
                        emit.last   = 1'b1;
                     end else begin
                        state_in = S_LDI;
                     end
                  end
                  ACT_LIST: begin
                     if (cnt_ff == '0) begin
                        emit.valid  = 1'b1;
                        emit.status = ST_MISSING;
                        emit.last   = 1'b1;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // pipelined key search, one entry per cycle
         S_SCAN: begin
            pend_in = idx_lt_cnt;
            pidx_in = idx_ff[IDX_W-1:0];
            idx_in  = idx_lt_cnt ? idx_p1 : idx_ff;
            if (key_eq) begin
               pend_in     = 1'b0;
               state_in    = S_IDLE;
               emit.valid  = 1'b1;
               emit.last   = 1'b1;
               emit.status = ST_DONE;
               case (act_ff)
                  ACT_INSERT: begin
                     emit.status = ST_PRESENT;
                  end
                  ACT_DELETE: begin
                     emit.rec = rd_data;
                     idx_in   = CNT_W'(pidx_ff);
                     state_in = S_DEL;
                  end
                  ACT_UPDATE: begin
                     wr.en         = 1'b1;
                     wr.addr       = pidx_ff;
                     wr.rec.key    = rd_data.key;
                     wr.rec.days   = days_ff;
                     emit.rec.key  = rd_data.key;
                     emit.rec.days = days_ff;
                  end
                  default: begin
                     emit.rec = rd_data;
                  end
               endcase
            end else if (!pend_ff && !idx_lt_cnt) begin
               pend_in    = 1'b0;
               state_in   = S_IDLE;
               emit.valid = 1'b1;
               emit.last  = 1'b1;
               if (act_ff == ACT_INSERT) begin
                  if (cnt_ff == CNT_W'(TABLE_DEPTH)) begin
                     emit.status = ST_FULL;
                  end else begin
                     wr.en         = 1'b1;
                     wr.addr       = cnt_ff[IDX_W-1:0];
                     wr.rec.key    = key_ff;
                     wr.rec.days   = days_ff;
                     cnt_in        = cnt_ff + CNT_W'(1);
                     emit.status   = ST_DONE;
                     emit.rec.key  = key_ff;
                     emit.rec.days = days_ff;
                  end
               end else begin
                  emit.status = ST_MISSING;
               end
            end
         end
         // close the gap: read entry k+1, then write it at k
         S_DEL: begin
            if (idx_p1 < cnt_ff) begin
               rd_addr  = idx_p1[IDX_W-1:0];
               state_in = S_DEL_WR;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_IDLE;
            end
         end
         S_DEL_WR: begin
            wr.en    = 1'b1;
            wr.addr  = idx_ff[IDX_W-1:0];
            wr.rec   = rd_data;
            idx_in   = idx_p1;
            state_in = S_DEL;
         end
         // stream every record, one per cycle
         S_LIST: begin
            pend_in = idx_lt_cnt;
            pidx_in = idx_ff[IDX_W-1:0];
            idx_in  = idx_lt_cnt ? idx_p1 : idx_ff;
            if (pend_ff) begin
               emit.valid  = 1'b1;
               emit.status = ST_DONE;
               emit.rec    = rd_data;
               emit.last   = pidx_last;
               if (pidx_last) begin
                  pend_in  = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         // exchange sort: hold entry i in cur, sweep j above it
         S_LDI: begin
            rd_addr  = i_ff[IDX_W-1:0];
            idx_in   = i_p1;
            state_in = S_LDI_W;
         end
         S_LDI_W: begin
            cur_in   = rd_data;
            state_in = S_JRD;
         end
         S_JRD: begin
            if (idx_lt_cnt) begin
               state_in = S_JCMP;
            end else begin
               wr.en   = 1'b1;
               wr.addr = i_ff[IDX_W-1:0];
               wr.rec  = cur_ff;
               i_in    = i_p1;
               if (i_p2 < cnt_ff) begin
                  state_in = S_LDI;
               end else begin
                  emit.valid  = 1'b1;
                  emit.status = ST_DONE;
                  emit.last   = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_JCMP: begin
            if (days_gt) begin
               wr.en   = 1'b1;
               wr.addr = idx_ff[IDX_W-1:0];
               wr.rec  = cur_ff;
               cur_in  = rd_data;
            end
            idx_in   = idx_p1;
            state_in = S_JRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      key_ff  <= key_in;
      days_ff <= days_in;
      idx_ff  <= idx_in;
      i_ff    <= i_in;
      pidx_ff <= pidx_in;
      cur_ff  <= cur_in;
   end

   // checks
   `KRT_ASSERT_IMPLY(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(TABLE_DEPTH))
   `KRT_ASSERT_IMPLY(a_wr_in_fill, clock, reset, wr.en, (CNT_W'(wr.addr) <= cnt_ff) && (CNT_W'(wr.addr) < CNT_W'(TABLE_DEPTH)))
   `KRT_ASSERT_IMPLY(a_emit_at_work, clock, reset, emit.valid, busy || start)
   `KRT_ASSERT_NEXT(a_lookup_busy, clock, reset, !busy && start && (req.action == ACT_FIND || req.action == ACT_DELETE), busy)

endmodule

// ===== hdl/keyed_record_table_with_sort.sv =====
// top level of the keyed record table with exchange sort
// depends on krt_pkg, krt_mem, krt_seq and krt_out
//
// An item is taken when start is high and busy is low; busy stays high until
// the item's work is finished. Results appear on rsp_data for one cycle,
// flagged by rsp_valid, in the cycle after they are formed; the receiver
// cannot stall, so it must take every strobe, and rsp_data.last marks the
// final result of an item. All work goes through a single record memory
// with one write port and one registered read port: insert, delete, update
// and find scan keys one per cycle; a delete then moves each later record
// down, a read state and a write state per record, and drops the fill count
// at the end; list gives one record per cycle; sort loads entry i, reads and
// compares each entry above it, and writes the held entry back at i. Record
// contents are undefined until written and of the table only the fill count
// is cleared by reset, so there is no clearing pass. The pay rate is written
// through csr_wr_en and csr_wr_data; the user must write it only while the
// block is idle, which the block itself does not enforce.
module keyed_record_table_with_sort import krt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req_data,
   output logic              busy,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [RATE_W-1:0] csr_wr_data
);

   wr_type           wr;
   rec_type          rd_data;
   logic [IDX_W-1:0] rd_addr;
   emit_type         emit;

   // record storage
   krt_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // control sequencer
   krt_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req_data),
      .rd_data (rd_data),
      .busy    (busy),
      .rd_addr (rd_addr),
      .wr      (wr),
      .emit    (emit)
   );

   // pay derivation and result register
   krt_out u_out (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .emit        (emit),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule
